[rtl/sha_pkg.sv]
// Package: SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CountW = 55;
    localparam int unsigned QueueDepth = 4;

    // Word request from the front part to the compression engine.
    typedef struct packed {
        logic [WordW-1:0] word;
        logic             blk_end;
        logic             msg_end;
    } t_req;

    typedef logic [WordW-1:0] t_word;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic t_word round_const(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word sml_s0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sml_s1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[rtl/sha_front.sv]
// Front part: counts words, pads the message and issues schedule word requests.
`timescale 1ns / 1ps
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_data_word,
    input  logic [2:0]    i_valid_bytes,
    input  logic          i_last,
    input  logic          i_push,
    output logic          o_full,
    output sha_pkg::t_req o_req,
    output logic          o_req_vld,
    input  logic          i_req_rdy
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_TAKE = 3'b001,
        ST_PAD  = 3'b010,
        ST_LEN  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_pos, n_pos;
    logic [CountW-1:0] r_blocks, n_blocks;
    logic [63:0]       r_len, n_len;
    logic              r_mark, n_mark;   // 0x80 marker still owed
    logic              r_len_lo, n_len_lo;

    logic [2:0]  nb;
    logic [31:0] keep, marker, pad_word;
    logic        go;

    always_comb begin
        nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        case (nb)
            3'd0: begin keep = 32'h0; marker = 32'h8000_0000; end
            3'd1: begin keep = 32'hff00_0000; marker = 32'h0080_0000; end
            3'd2: begin keep = 32'hffff_0000; marker = 32'h0000_8000; end
            3'd3: begin keep = 32'hffff_ff00; marker = 32'h0000_0080; end
            default: begin keep = 32'hffff_ffff; marker = 32'h0; end
        endcase
        pad_word = r_mark ? 32'h8000_0000 : 32'h0;
    end

    assign o_full = (r_state != ST_TAKE) || !i_req_rdy;
    assign go     = i_req_rdy;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_blocks = r_blocks;
        n_len    = r_len;
        n_mark   = r_mark;
        n_len_lo = r_len_lo;
        o_req_vld = 1'b0;
        o_req     = '0;
        unique case (r_state)
            ST_TAKE: begin
                if (i_push && go) begin
                    o_req_vld     = 1'b1;
                    o_req.blk_end = (r_pos == 4'd15);
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'd15) n_blocks = r_blocks + 1'b1;
                    if (!i_last) begin
                        o_req.word = i_data_word;
                    end else begin
                        o_req.word = (i_data_word & keep) | marker;
                        n_len  = {r_blocks, 9'd0} + {55'd0, r_pos, 5'd0}
                               + {58'd0, nb, 3'd0};
                        n_mark = (nb == 3'd4);
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // fill until slot 14, then length words
                if (!r_mark && r_pos == 4'd14) begin
                    n_state  = ST_LEN;
                    n_len_lo = 1'b0;
                end else if (go) begin
                    o_req_vld     = 1'b1;
                    o_req.word    = pad_word;
                    o_req.blk_end = (r_pos == 4'd15);
                    n_mark = 1'b0;
                    n_pos  = r_pos + 4'd1;
                end
            end
            ST_LEN: begin
                if (go) begin
                    o_req_vld = 1'b1;
                    o_req.word = r_len_lo ? r_len[31:0] : r_len[63:32];
                    o_req.blk_end = r_len_lo;
                    o_req.msg_end = r_len_lo;
                    n_pos    = r_pos + 4'd1;
                    n_len_lo = 1'b1;
                    if (r_len_lo) begin
                        n_state  = ST_TAKE;
                        n_pos    = 4'd0;
                        n_blocks = '0;
                    end
                end
            end
            default: n_state = ST_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_TAKE;
            r_pos    <= '0;
            r_blocks <= '0;
            r_mark   <= 1'b0;
            r_len_lo <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_blocks <= n_blocks;
            r_mark   <= n_mark;
            r_len_lo <= n_len_lo;
        end
        r_len <= n_len;
    end
endmodule

[rtl/sha_queue.sv]
// Request queue between the front part and the compression engine.
`timescale 1ns / 1ps
module sha_queue #(
    parameter int unsigned Depth = sha_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sha_pkg::t_req i_req,
    input  logic          i_push,
    output logic          o_rdy,
    output sha_pkg::t_req o_req,
    output logic          o_vld,
    input  logic          i_pop
);
    import sha_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_req          r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_rdy = (r_cnt != (AW+1)'(Depth));
    assign o_vld = (r_cnt != '0);
    assign o_req = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_rdy)
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop && o_vld)
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && o_rdy) - (AW+1)'(i_pop && o_vld);
        end
        if (i_push && o_rdy) r_mem[r_wp] <= i_req;
    end
endmodule

[rtl/sha_engine.sv]
// Back part: schedule window, 64-round compression and digest output buffer.
`timescale 1ns / 1ps
module sha_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sha_pkg::t_req i_req,
    input  logic          i_vld,
    output logic          o_pop,
    output logic [31:0]   o_digest_word,
    output logic          o_digest_last,
    output logic          o_empty,
    input  logic          i_pop
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_RND  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state      r_state;
    t_word       r_w [16];
    t_word       r_h [8];
    t_word       r_v [8];
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic [2:0]  r_oi;

    t_word w_new, wr, t1, t2, ch, mj;

    always_comb begin
        w_new = r_w[0] + sml_s0(r_w[1]) + r_w[9] + sml_s1(r_w[14]);
        wr    = r_w[0];
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_s1(r_v[4]) + ch + round_const(r_rnd) + wr;
        t2    = big_s0(r_v[0]) + mj;
    end

    assign o_pop         = (r_state == ST_LOAD) && i_vld;
    assign o_empty       = (r_state != ST_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_digest_last = (r_oi == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_oi    <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (i_vld) begin
                        // window shifts so the oldest word sits in slot 0
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= i_req.word;
                        if (i_req.blk_end) begin
                            r_state <= ST_RND;
                            r_rnd   <= '0;
                            r_fin   <= i_req.msg_end;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end
                    end
                end
                ST_RND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[0] <= t1 + t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oi    <= '0;
                    r_state <= r_fin ? ST_OUT : ST_LOAD;
                end
                ST_OUT: begin
                    if (i_pop) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_state <= ST_LOAD;
                            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end
endmodule

[rtl/sha256_message_hasher_unit.sv]
// Top level: SHA-256 hasher with word queue in front of the compression engine.
`timescale 1ns / 1ps
// Per 16-word block the engine loads the words, runs the 64 rounds and adds
//   the result to the hash state; it takes no new word until the add is done.
// After the last word the engine finishes one or two padded blocks, then
//   gives 8 digest words, one per cycle while pop is held.
// Reset: i_rst_n synchronous active low; hash state returns to the initial
//   values, counters and queue clear. No clearing pass.
module sha256_message_hasher_unit #(
    parameter int unsigned QDepth = sha_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last,
    input  logic        push,
    output logic        full,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last,
    output logic        empty,
    input  logic        pop
);
    import sha_pkg::*;

    t_req f_req, q_req;
    logic f_vld, q_rdy, q_vld, e_pop;

    // front part: padding and length insertion, at most one request per cycle while the queue has room
    sha_front u_front (
        .i_clk, .i_rst_n, .i_data_word, .i_valid_bytes, .i_last,
        .i_push(push), .o_full(full),
        .o_req(f_req), .o_req_vld(f_vld), .i_req_rdy(q_rdy)
    );

    // short queue decouples padding from the round engine
    sha_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_req(f_req), .i_push(f_vld), .o_rdy(q_rdy),
        .o_req(q_req), .o_vld(q_vld), .i_pop(e_pop)
    );

    // back part: compression and digest readout
    sha_engine u_engine (
        .i_clk, .i_rst_n,
        .i_req(q_req), .i_vld(q_vld), .o_pop(e_pop),
        .o_digest_word, .o_digest_last, .o_empty(empty), .i_pop(pop)
    );
endmodule
